FILE: sv/wqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqp_pkg
// Shared types, character codes and lookup functions for the Wi-Fi QR
// payload parser.
// ----------------------------------------------------------------------------
package wqp_pkg;

    // Default field capacities, counting the terminator slot
    localparam int SSID_CAPACITY_DEF = 64;
    localparam int PASS_CAPACITY_DEF = 64;
    localparam int AUTH_CAPACITY_DEF = 16;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 6;
    localparam int AUTH_W  = 4;
    localparam int PIDX_W  = 3;
    localparam int CAP_W   = 7;

    localparam logic [PIDX_W-1:0] PREFIX_LEN = 3'd5;
    localparam logic [POS_W-1:0]  OPEN_LEN   = 6'd6;
    localparam logic [AUTH_W-1:0] OPEN_CNT   = 4'd6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_KEY    = 7'b0000010,
        PH_COLON  = 7'b0000100,
        PH_SKIP   = 7'b0001000,
        PH_VALUE  = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_REJECT = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_SSID = 2'd1,
        TGT_PASS = 2'd2,
        TGT_AUTH = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        KIND_SSID    = 2'd0,
        KIND_PASS    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    // One result word
    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_value;
        logic              valid_res;
        logic [LEN_W-1:0]  ssid_length;
        logic [LEN_W-1:0]  pass_length;
        logic              open_network;
    } result_t;

    // Up to two result words produced by one input word, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [PIDX_W-1:0] idx);
        case (idx)
            3'd0:    prefix_char = 8'h57;  // W
            3'd1:    prefix_char = 8'h49;  // I
            3'd2:    prefix_char = 8'h46;  // F
            3'd3:    prefix_char = 8'h49;  // I
            3'd4:    prefix_char = 8'h3A;  // :
            default: prefix_char = 8'h00;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] open_char(input logic [POS_W-1:0] idx);
        case (idx)
            6'd0:    open_char = 8'h6E;  // n
            6'd1:    open_char = 8'h6F;  // o
            6'd2:    open_char = 8'h70;  // p
            6'd3:    open_char = 8'h61;  // a
            6'd4:    open_char = 8'h73;  // s
            6'd5:    open_char = 8'h73;  // s
            default: open_char = 8'h00;
        endcase
    endfunction

endpackage

FILE: sv/wqp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqp_core
// Parse state registers and the single-pass next-state logic; turns one
// payload byte into zero, one or two result words.
// ----------------------------------------------------------------------------
module wqp_core #(
    parameter int SSID_CAPACITY = wqp_pkg::SSID_CAPACITY_DEF,
    parameter int PASS_CAPACITY = wqp_pkg::PASS_CAPACITY_DEF,
    parameter int AUTH_CAPACITY = wqp_pkg::AUTH_CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           char_code,
    input  logic                 end_of_payload,
    output wqp_pkg::push_t       push
);
    import wqp_pkg::*;

    localparam logic [CAP_W-1:0] SSID_CAP = CAP_W'(SSID_CAPACITY);
    localparam logic [CAP_W-1:0] PASS_CAP = CAP_W'(PASS_CAPACITY);
    localparam logic [CAP_W-1:0] AUTH_CAP = CAP_W'(AUTH_CAPACITY);

    phase_t              phase_reg,       phase_next;
    logic [PIDX_W-1:0]   prefix_idx_reg,  prefix_idx_next;
    logic                escape_reg,      escape_next;
    target_t             target_reg,      target_next;
    logic [POS_W-1:0]    wr_idx_reg,      wr_idx_next;
    logic [LEN_W-1:0]    ssid_cnt_reg,    ssid_cnt_next;
    logic [LEN_W-1:0]    pass_cnt_reg,    pass_cnt_next;
    logic [AUTH_W-1:0]   auth_cnt_reg,    auth_cnt_next;
    logic                auth_match_reg,  auth_match_next;

    logic                do_store;
    logic                do_start;
    logic                char_out;
    logic [CAP_W-1:0]    wr_inc;
    logic [CAP_W-1:0]    cap;
    logic                matched;
    logic                is_open;
    result_t             char_res;
    result_t             sum_res;

    assign wr_inc = {1'b0, wr_idx_reg} + 7'd1;

    always_comb begin
        case (target_reg)
            TGT_SSID: cap = SSID_CAP;
            TGT_PASS: cap = PASS_CAP;
            TGT_AUTH: cap = AUTH_CAP;
            default:  cap = '0;
        endcase
    end

    // Next parse state for one byte
    always_comb begin
        phase_next      = phase_reg;
        prefix_idx_next = prefix_idx_reg;
        escape_next     = escape_reg;
        target_next     = target_reg;
        wr_idx_next     = wr_idx_reg;
        ssid_cnt_next   = ssid_cnt_reg;
        pass_cnt_next   = pass_cnt_reg;
        auth_cnt_next   = auth_cnt_reg;
        auth_match_next = auth_match_reg;
        do_store        = 1'b0;
        do_start        = 1'b0;
        char_out        = 1'b0;
        char_res        = '0;
        sum_res         = '0;
        matched         = 1'b0;
        is_open         = 1'b0;

        if (phase_reg == PH_DONE || phase_reg == PH_REJECT) begin
            // hold: parsing has ended
        end else if (char_code == CH_NUL) begin
            phase_next = (phase_reg == PH_PREFIX) ? PH_REJECT : PH_DONE;
        end else begin
            case (phase_reg)
                PH_PREFIX: begin
                    if (prefix_idx_reg < PREFIX_LEN &&
                        char_code == prefix_char(prefix_idx_reg)) begin
                        prefix_idx_next = prefix_idx_reg + 3'd1;
                        if (prefix_idx_next == PREFIX_LEN) begin
                            phase_next = PH_KEY;
                        end
                    end else begin
                        phase_next = PH_REJECT;
                    end
                end
                PH_KEY: begin
                    if (char_code != CH_SEMI) begin
                        if (char_code == CH_S)      target_next = TGT_SSID;
                        else if (char_code == CH_P) target_next = TGT_PASS;
                        else if (char_code == CH_T) target_next = TGT_AUTH;
                        else                        target_next = TGT_NONE;
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON: begin
                    if (char_code == CH_COLON)     do_start   = 1'b1;
                    else if (char_code == CH_SEMI) phase_next = PH_KEY;
                    else                           phase_next = PH_SKIP;
                end
                PH_SKIP: begin
                    if (char_code == CH_SEMI) phase_next = PH_KEY;
                end
                PH_VALUE: begin
                    if (escape_reg) begin
                        escape_next = 1'b0;
                        do_store    = 1'b1;
                    end else if (char_code == CH_BSL) begin
                        escape_next = 1'b1;
                    end else if (char_code == CH_SEMI) begin
                        phase_next = PH_KEY;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                default: phase_next = PH_REJECT;
            endcase
        end

        // Open a new value and clear its field
        if (do_start) begin
            phase_next  = PH_VALUE;
            wr_idx_next = '0;
            escape_next = 1'b0;
            case (target_reg)
                TGT_SSID: ssid_cnt_next = '0;
                TGT_PASS: pass_cnt_next = '0;
                TGT_AUTH: begin
                    auth_cnt_next   = '0;
                    auth_match_next = 1'b1;
                end
                default: ;
            endcase
        end

        // Store one character, drop it once the field is full
        if (do_store && target_reg != TGT_NONE && wr_inc < cap) begin
            wr_idx_next = wr_inc[POS_W-1:0];
            case (target_reg)
                TGT_SSID: begin
                    char_out      = 1'b1;
                    char_res.kind = KIND_SSID;
                    ssid_cnt_next = wr_inc[LEN_W-1:0];
                end
                TGT_PASS: begin
                    char_out      = 1'b1;
                    char_res.kind = KIND_PASS;
                    pass_cnt_next = wr_inc[LEN_W-1:0];
                end
                default: begin
                    if (wr_idx_reg < OPEN_LEN && char_code != open_char(wr_idx_reg)) begin
                        auth_match_next = 1'b0;
                    end
                    auth_cnt_next = wr_inc[AUTH_W-1:0];
                end
            endcase
            char_res.position   = wr_idx_reg;
            char_res.char_value = char_code;
        end

        // Summary on the last byte, then return to the reset state
        matched = (phase_next != PH_PREFIX) && (phase_next != PH_REJECT);
        is_open = (auth_cnt_next == OPEN_CNT) && auth_match_next;
        sum_res.kind         = KIND_SUMMARY;
        sum_res.ssid_length  = matched ? ssid_cnt_next : '0;
        sum_res.pass_length  = (matched && !is_open) ? pass_cnt_next : '0;
        sum_res.valid_res    = matched && (ssid_cnt_next != '0);
        sum_res.open_network = matched && is_open;

        if (end_of_payload) begin
            phase_next      = PH_PREFIX;
            prefix_idx_next = '0;
            escape_next     = 1'b0;
            target_next     = TGT_NONE;
            wr_idx_next     = '0;
            ssid_cnt_next   = '0;
            pass_cnt_next   = '0;
            auth_cnt_next   = '0;
            auth_match_next = 1'b1;
        end
    end

    // Order the result words: character first, then summary
    always_comb begin
        push.count  = 2'(char_out) + 2'(end_of_payload);
        push.first  = char_out ? char_res : sum_res;
        push.second = sum_res;
        if (!in_accept) begin
            push.count = 2'd0;
        end
    end

    // Advance parse state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_PREFIX;
            prefix_idx_reg <= '0;
            escape_reg     <= 1'b0;
            target_reg     <= TGT_NONE;
            wr_idx_reg     <= '0;
            ssid_cnt_reg   <= '0;
            pass_cnt_reg   <= '0;
            auth_cnt_reg   <= '0;
            auth_match_reg <= 1'b1;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            prefix_idx_reg <= prefix_idx_next;
            escape_reg     <= escape_next;
            target_reg     <= target_next;
            wr_idx_reg     <= wr_idx_next;
            ssid_cnt_reg   <= ssid_cnt_next;
            pass_cnt_reg   <= pass_cnt_next;
            auth_cnt_reg   <= auth_cnt_next;
            auth_match_reg <= auth_match_next;
        end
    end

endmodule

FILE: sv/wqp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqp_result_fifo
// Four-entry result queue: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module wqp_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  wqp_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output wqp_pkg::result_t  out_word
);
    import wqp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg,  count_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic               pop;

    assign room       = count_reg <= (PTR_W+1)'(DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_word   = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    // Move pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the words in order
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

FILE: sv/wifi_qr_payload_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_qr_payload_parser_unit
// Wi-Fi QR payload parser: checks the WIFI: prefix, splits key:value
// fields, emits SSID and password characters and a summary on the last byte.
// ----------------------------------------------------------------------------
// Results pass through the registered result queue before they appear on m_valid.
// Throughput: one byte per cycle; a byte that yields a character and the
//   summary puts two words into the four-entry result queue, which drains
//   one word per cycle while m_ready is high; s_ready needs two free slots.
// Reset: synchronous active-low aresetn clears parse state and empties the queue.
module wifi_qr_payload_parser_unit #(
    parameter int SSID_CAPACITY = wqp_pkg::SSID_CAPACITY_DEF,
    parameter int PASS_CAPACITY = wqp_pkg::PASS_CAPACITY_DEF,
    parameter int AUTH_CAPACITY = wqp_pkg::AUTH_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [5:0]  m_position,
    output logic [7:0]  m_char_value,
    output logic        m_valid_res,
    output logic [5:0]  m_ssid_length,
    output logic [5:0]  m_pass_length,
    output logic        m_open_network
);
    import wqp_pkg::*;

    push_t   push;
    result_t out_word;
    logic    room;

    // Accept a word whenever the queue can hold two more results
    assign s_ready = room;

    wqp_core #(
        .SSID_CAPACITY (SSID_CAPACITY),
        .PASS_CAPACITY (PASS_CAPACITY),
        .AUTH_CAPACITY (AUTH_CAPACITY)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (s_valid && s_ready),
        .char_code      (s_char_code),
        .end_of_payload (s_end_of_payload),
        .push           (push)
    );

    wqp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    // Unpack the head result word
    assign m_kind         = out_word.kind;
    assign m_position     = out_word.position;
    assign m_char_value   = out_word.char_value;
    assign m_valid_res    = out_word.valid_res;
    assign m_ssid_length  = out_word.ssid_length;
    assign m_pass_length  = out_word.pass_length;
    assign m_open_network = out_word.open_network;

endmodule

FILE: sim/wifi_qr_payload_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_qr_payload_parser_unit_tb
// Self-checking bench for the Wi-Fi QR payload parser. A behavioral parser
// model inside a small scoreboard predicts every character and summary word
// from the accepted input bytes. Directed payloads cover the prefix, escape
// and termination corners; random payloads, mostly well formed, follow. Both
// channels idle at random, with one long output hold-off and periodic drains.
// ----------------------------------------------------------------------------
module wifi_qr_payload_parser_unit_tb;
    import wqp_pkg::*;

    localparam int          N_ITEMS    = 1650;
    localparam int          LONG_HOLD  = 300;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          TAIL_WAIT  = 16;
    localparam logic [39:0] WIFI_TAG   = "WIFI:";
    localparam logic [47:0] OPEN_TAG   = "nopass";

    // ------------------------------------------------------------------------
    // Parser model and result store
    // ------------------------------------------------------------------------
    class qr_parse_scoreboard;
        phase_t     ph;
        logic [2:0] pidx;
        bit         esc;
        target_t    tgt;
        logic [5:0] widx;
        logic [5:0] ssid_cnt;
        logic [5:0] pass_cnt;
        logic [3:0] auth_cnt;
        bit         auth_ok;

        result_t    parsed_words[$];
        int         mismatches;
        int         bytes_parsed;
        int         words_seen;
        int         n_ssid, n_pass, n_summary, n_valid, n_open;

        function new();
            clear_parse();
            mismatches   = 0;
            bytes_parsed = 0;
            words_seen   = 0;
            n_ssid       = 0;
            n_pass       = 0;
            n_summary    = 0;
            n_valid      = 0;
            n_open       = 0;
        endfunction

        function void clear_parse();
            ph       = PH_PREFIX;
            pidx     = '0;
            esc      = 1'b0;
            tgt      = TGT_NONE;
            widx     = '0;
            ssid_cnt = '0;
            pass_cnt = '0;
            auth_cnt = '0;
            auth_ok  = 1'b1;
        endfunction

        function int pending();
            return parsed_words.size();
        endfunction

        // Store one value character, dropping it once the field is full
        function void keep_char(logic [7:0] c);
            int      room;
            int      j;
            result_t w;
            case (tgt)
                TGT_SSID: room = SSID_CAPACITY_DEF;
                TGT_PASS: room = PASS_CAPACITY_DEF;
                TGT_AUTH: room = AUTH_CAPACITY_DEF;
                default:  room = 0;
            endcase
            if (tgt == TGT_NONE || int'(widx) + 1 >= room)
                return;
            w = '0;
            if (tgt == TGT_SSID) begin
                w.kind       = KIND_SSID;
                w.position   = widx;
                w.char_value = c;
                parsed_words.push_back(w);
                ssid_cnt = widx + 6'd1;
            end else if (tgt == TGT_PASS) begin
                w.kind       = KIND_PASS;
                w.position   = widx;
                w.char_value = c;
                parsed_words.push_back(w);
                pass_cnt = widx + 6'd1;
            end else begin
                j = int'(widx);
                if (j < 6 && c != OPEN_TAG[8*(5-j) +: 8])
                    auth_ok = 1'b0;
                auth_cnt = 4'(j + 1);
            end
            widx = widx + 6'd1;
        endfunction

        // Advance the parse state by one accepted byte
        function void parse_byte(logic [7:0] c, logic last);
            bit      matched;
            bit      is_open;
            result_t w;
            if (ph != PH_DONE && ph != PH_REJECT) begin
                bytes_parsed++;
                if (c == CH_NUL) begin
                    ph = (ph == PH_PREFIX) ? PH_REJECT : PH_DONE;
                end else begin
                    case (ph)
                        PH_PREFIX: begin
                            if (pidx < PREFIX_LEN && c == WIFI_TAG[8*(4-int'(pidx)) +: 8]) begin
                                pidx = pidx + 3'd1;
                                if (pidx == PREFIX_LEN)
                                    ph = PH_KEY;
                            end else begin
                                ph = PH_REJECT;
                            end
                        end
                        PH_KEY: begin
                            if (c != CH_SEMI) begin
                                if (c == CH_S)      tgt = TGT_SSID;
                                else if (c == CH_P) tgt = TGT_PASS;
                                else if (c == CH_T) tgt = TGT_AUTH;
                                else                tgt = TGT_NONE;
                                ph = PH_COLON;
                            end
                        end
                        PH_COLON: begin
                            if (c == CH_COLON) begin
                                ph   = PH_VALUE;
                                widx = '0;
                                esc  = 1'b0;
                                if (tgt == TGT_SSID) begin
                                    ssid_cnt = '0;
                                end else if (tgt == TGT_PASS) begin
                                    pass_cnt = '0;
                                end else if (tgt == TGT_AUTH) begin
                                    auth_cnt = '0;
                                    auth_ok  = 1'b1;
                                end
                            end else if (c == CH_SEMI) begin
                                ph = PH_KEY;
                            end else begin
                                ph = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            if (c == CH_SEMI)
                                ph = PH_KEY;
                        end
                        PH_VALUE: begin
                            if (esc) begin
                                esc = 1'b0;
                                keep_char(c);
                            end else if (c == CH_BSL) begin
                                esc = 1'b1;
                            end else if (c == CH_SEMI) begin
                                ph = PH_KEY;
                            end else begin
                                keep_char(c);
                            end
                        end
                        default: ph = PH_REJECT;
                    endcase
                end
            end else if (last) begin
                bytes_parsed++;
            end

            // Close the payload with its summary and restart
            if (last) begin
                matched       = (ph != PH_PREFIX && ph != PH_REJECT);
                is_open       = (auth_cnt == OPEN_CNT && auth_ok);
                w             = '0;
                w.kind        = KIND_SUMMARY;
                w.ssid_length = matched ? ssid_cnt : 6'd0;
                w.pass_length = (matched && !is_open) ? pass_cnt : 6'd0;
                w.valid_res   = matched && (w.ssid_length != 6'd0);
                w.open_network = matched && is_open;
                parsed_words.push_back(w);
                clear_parse();
            end
        endfunction

        // Compare one accepted output word with the oldest prediction
        function void compare_word(result_t got);
            result_t want;
            words_seen++;
            if (parsed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected word: kind=%0d pos=%0d char=%02h",
                             $realtime, got.kind, got.position, got.char_value);
                return;
            end
            want = parsed_words.pop_front();
            if (got.kind !== want.kind || got.position !== want.position ||
                got.char_value !== want.char_value || got.valid_res !== want.valid_res ||
                got.ssid_length !== want.ssid_length ||
                got.pass_length !== want.pass_length ||
                got.open_network !== want.open_network) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] word %0d mismatch", $realtime, words_seen);
                    $display("  expected kind=%0d pos=%0d char=%02h valid=%0b ssid=%0d pass=%0d open=%0b",
                             want.kind, want.position, want.char_value, want.valid_res,
                             want.ssid_length, want.pass_length, want.open_network);
                    $display("  actual   kind=%0d pos=%0d char=%02h valid=%0b ssid=%0d pass=%0d open=%0b",
                             got.kind, got.position, got.char_value, got.valid_res,
                             got.ssid_length, got.pass_length, got.open_network);
                end
            end else begin
                case (want.kind)
                    KIND_SSID: n_ssid++;
                    KIND_PASS: n_pass++;
                    default: begin
                        n_summary++;
                        if (want.valid_res)
                            n_valid++;
                        if (want.open_network)
                            n_open++;
                    end
                endcase
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       s_end_of_payload;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [5:0] m_position;
    logic [7:0] m_char_value;
    logic       m_valid_res;
    logic [5:0] m_ssid_length;
    logic [5:0] m_pass_length;
    logic       m_open_network;

    qr_parse_scoreboard sb;
    logic [7:0]         pay_bytes[$];
    int                 burst_left;
    int                 n_payloads;
    int                 cycle_count;
    bit                 hold_off_req;

    wifi_qr_payload_parser_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_payload (s_end_of_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_position       (m_position),
        .m_char_value     (m_char_value),
        .m_valid_res      (m_valid_res),
        .m_ssid_length    (m_ssid_length),
        .m_pass_length    (m_pass_length),
        .m_open_network   (m_open_network)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && s_valid && s_ready)
            sb.parse_byte(s_char_code, s_end_of_payload);
        if (aresetn && m_valid && m_ready) begin
            got.kind         = m_kind;
            got.position     = m_position;
            got.char_value   = m_char_value;
            got.valid_res    = m_valid_res;
            got.ssid_length  = m_ssid_length;
            got.pass_length  = m_pass_length;
            got.open_network = m_open_network;
            sb.compare_word(got);
        end
    end

    // Stall the result channel in stretches of changing character
    initial begin
        int rx_mode;
        int stretch_left;
        int rx_tick;
        m_ready      = 1'b0;
        stretch_left = 0;
        rx_mode      = 0;
        rx_tick      = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    stretch_left = $urandom_range(4, 60);
                end
                stretch_left--;
                rx_tick++;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((rx_tick % 5) < 2);
                endcase
            end
        end
    end

    // Bound the run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one word, with a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_char_code      <= c;
        s_end_of_payload <= last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_payload();
        for (int i = 0; i < pay_bytes.size(); i++)
            send_byte(pay_bytes[i], i == pay_bytes.size() - 1);
        pay_bytes.delete();
    endtask

    // Hold the input until every predicted word has come out
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pay_bytes.push_back(s[i]);
    endtask

    // Random value text; escape the separators, and now and then anything
    task automatic add_value(input int len);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            ch = 8'($urandom_range(1, 255));
            if (ch == CH_SEMI || ch == CH_BSL || $urandom_range(0, 19) == 0)
                pay_bytes.push_back(CH_BSL);
            pay_bytes.push_back(ch);
        end
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 5)
            return $urandom_range(55, 70);
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [7:0] pick_other_key();
        logic [7:0] k;
        do k = 8'($urandom_range(1, 255));
        while (k == CH_S || k == CH_P || k == CH_T || k == CH_SEMI);
        return k;
    endfunction

    // Build one random payload: mostly well formed, some broken or noise
    task automatic build_payload();
        int         mode;
        int         n_fields;
        int         sel;
        int         cut;
        logic [7:0] ch;
        mode = $urandom_range(0, 99);
        if (mode < 80) begin
            add_text("WIFI:");
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0, 1, 2: begin
                        add_text("S:");
                        add_value(pick_len());
                    end
                    3, 4: begin
                        add_text("P:");
                        add_value(pick_len());
                    end
                    5, 6: begin
                        add_text("T:");
                        case ($urandom_range(0, 5))
                            0, 1: add_text("nopass");
                            2:    add_text("nopas");
                            3:    add_text("nopasss");
                            4:    add_text("nop\\ass");
                            default: add_value($urandom_range(0, 17));
                        endcase
                    end
                    7: begin
                        pay_bytes.push_back(pick_other_key());
                        pay_bytes.push_back(CH_COLON);
                        add_value(pick_len());
                    end
                    8: begin
                        // key without a colon; escapes do not apply here
                        case ($urandom_range(0, 3))
                            0:       pay_bytes.push_back(CH_S);
                            1:       pay_bytes.push_back(CH_P);
                            2:       pay_bytes.push_back(CH_T);
                            default: pay_bytes.push_back(pick_other_key());
                        endcase
                        do ch = 8'($urandom_range(1, 255));
                        while (ch == CH_COLON || ch == CH_SEMI);
                        pay_bytes.push_back(ch);
                        if ($urandom_range(0, 1))
                            pay_bytes.push_back(CH_BSL);
                    end
                    default: begin
                        if ($urandom_range(0, 1))
                            pay_bytes.push_back(CH_S);
                    end
                endcase
                if (f < n_fields - 1 || $urandom_range(0, 1))
                    pay_bytes.push_back(CH_SEMI);
            end
            // Terminate early now and then, possibly mid-escape
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                pay_bytes.push_back(CH_BSL);
                pay_bytes.push_back(CH_NUL);
            end else if (sel < 14) begin
                pay_bytes.push_back(CH_NUL);
                repeat ($urandom_range(0, 3)) pay_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end else if (mode < 90) begin
            cut = $urandom_range(0, 5);
            for (int i = 0; i < cut; i++)
                pay_bytes.push_back(WIFI_TAG[8*(4-i) +: 8]);
            repeat ($urandom_range(1, 7)) pay_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12)) pay_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int failures;
        sb               = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_char_code      = '0;
        s_end_of_payload = 1'b0;
        hold_off_req     = 1'b0;
        burst_left       = 0;
        n_payloads       = 0;

        // Hold reset, then release it on a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Short payload, then a prefix mismatch
        add_text("WIF");
        send_payload();
        add_text("WXF");
        send_payload();
        // Zero byte before any prefix
        pay_bytes.push_back(CH_NUL);
        send_payload();
        // Escaped separator, extreme bytes, key without colon, bytes after zero
        add_text("WIFI:S:");
        pay_bytes.push_back(CH_BSL);
        pay_bytes.push_back(CH_SEMI);
        pay_bytes.push_back(8'hFF);
        pay_bytes.push_back(8'h80);
        pay_bytes.push_back(CH_SEMI);
        add_text("Kx;");
        pay_bytes.push_back(CH_NUL);
        add_text("Z");
        send_payload();
        drain_results();

        // Random payloads
        while (sb.bytes_parsed < N_ITEMS) begin
            build_payload();
            send_payload();
            n_payloads++;
            if (n_payloads == 10)
                hold_off_req = 1'b1;
            if (n_payloads % 15 == 0)
                drain_results();
        end

        // Drain and watch for stray words
        drain_results();
        repeat (TAIL_WAIT) @(posedge aclk);

        failures = sb.mismatches + sb.pending();
        $display("Ran %0d random payloads over %0d parsed bytes; checked %0d words.",
                 n_payloads, sb.bytes_parsed, sb.words_seen);
        $display("Matched %0d ssid and %0d password chars, %0d summaries (%0d valid, %0d open).",
                 sb.n_ssid, sb.n_pass, sb.n_summary, sb.n_valid, sb.n_open);
        if (sb.mismatches > 10)
            $display("%0d mismatches in total", sb.mismatches);
        if (sb.pending() != 0)
            $display("%0d predicted words never arrived", sb.pending());
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
